// ===== hdl/d8sd_pkg.sv =====
// Shared types and constants for the D8 steepest-descent direction block.
`timescale 1ns / 1ps
`default_nettype none
package d8sd_pkg;

    localparam int ELEV_W = 32;
    localparam int ROW_W = 16;
    localparam int COL_W = 10;
    localparam int DIR_W = 4;
    localparam int GW_W = 11;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIR_W-1:0] NO_FLOW = 4'd8;
    localparam logic [14:0] INV_SQRT2_Q15 = 15'd23170;

    localparam logic CFG_GRID_WIDTH = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 8;

    typedef struct packed {
        logic signed [ELEV_W-1:0] elevation;
        logic                     frame_start;
    } pixel_t;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             frame_last;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             border;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

endpackage
`default_nettype wire

// ===== hdl/d8sd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module d8sd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/d8sd_front.sv =====
// Front end: position counters, classification, line buffers and the 3x3 window.
`timescale 1ns / 1ps
`default_nettype none
module d8sd_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int ELEV_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [d8sd_pkg::GW_W-1:0]         grid_width,
    input  wire logic [d8sd_pkg::ROW_W-1:0]        grid_height,
    input  wire logic                              take,
    input  wire d8sd_pkg::pixel_t                  pixel,
    output logic                                   emit_now,
    output logic      [8:0][ELEV_BITS-1:0]         cells,
    output d8sd_pkg::meta_t                        meta
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > d8sd_pkg::GW_W) ?
                        $clog2(MAX_WIDTH + 1) : d8sd_pkg::GW_W;
    localparam int RW = d8sd_pkg::ROW_W;

    logic [AW-1:0]        col_reg;
    logic [RW-1:0]        row_reg;

    logic                 s1_valid_reg;
    logic                 s1_emit_reg;
    d8sd_pkg::meta_t      s1_meta_reg;
    logic [AW-1:0]        s1_idx_reg;
    logic [ELEV_BITS-1:0] s1_elev_reg;
    logic                 s1_fwd_reg;
    logic [ELEV_BITS-1:0] s1_fwd_data_reg;

    logic [8:0][ELEV_BITS-1:0] win_reg;
    d8sd_pkg::meta_t           meta_reg;
    d8sd_pkg::meta_t           meta_next;

    logic [ELEV_BITS-1:0] above_q;
    logic [ELEV_BITS-1:0] two_above_q;
    logic [ELEV_BITS-1:0] two_above_val;

    logic [WW-1:0]   gw;
    logic [WW-1:0]   eff_w;
    logic [RW-1:0]   eff_h;
    logic [RW-1:0]   r;
    logic [AW-1:0]   c;
    logic [WW-1:0]   c_ext;
    logic [WW-1:0]   c_next;
    logic [RW:0]     r_next;
    logic            col_wrap;
    logic            row_wrap;
    logic            emit;
    logic [RW-1:0]   cr;
    logic [WW-1:0]   cc;
    logic            border;
    logic [ELEV_BITS-1:0] elev;

    always_comb
    begin
        gw = WW'(grid_width);
        if (gw < WW'(5))
        begin
            eff_w = WW'(5);
        end
        else if (gw > WW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = gw;
        end
        eff_h = (grid_height < RW'(5)) ? RW'(5) : grid_height;

        r = pixel.frame_start ? '0 : row_reg;
        c = pixel.frame_start ? '0 : col_reg;
        c_ext = WW'(c);
        c_next = c_ext + WW'(1);
        r_next = {1'b0, r} + (RW+1)'(1);
        col_wrap = c_next >= eff_w;
        row_wrap = r_next >= {1'b0, eff_h};
        emit = (r >= RW'(2)) || ((r == RW'(1)) && (c != '0));
        cr = (c != '0) ? r - RW'(1) : r - RW'(2);
        cc = (c != '0) ? c_ext - WW'(1) : eff_w - WW'(1);
        border = (cr < RW'(2)) || (({1'b0, cr} + (RW+1)'(2)) >= {1'b0, eff_h}) ||
                 (cc < WW'(2)) || (({1'b0, cc} + (WW+1)'(2)) >= {1'b0, eff_w});
        elev = ELEV_BITS'($unsigned(pixel.elevation));
        emit_now = emit;
    end

    always_comb
    begin
        meta_next = s1_meta_reg;
        meta_next.valid = s1_valid_reg && s1_emit_reg;
    end

    d8sd_ram #(
        .WIDTH(ELEV_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_above (
        .clk(clk),
        .we(take),
        .waddr(c),
        .wdata(elev),
        .re(take),
        .raddr(c),
        .rdata(above_q)
    );

    d8sd_ram #(
        .WIDTH(ELEV_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_two_above (
        .clk(clk),
        .we(s1_valid_reg),
        .waddr(s1_idx_reg),
        .wdata(above_q),
        .re(take),
        .raddr(c),
        .rdata(two_above_q)
    );

    // The previous word writes the older line at the same edge this word reads it.
    assign two_above_val = s1_fwd_reg ? s1_fwd_data_reg : two_above_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
            meta_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (take)
            begin
                if (col_wrap)
                begin
                    col_reg <= '0;
                    row_reg <= row_wrap ? '0 : RW'(r_next);
                end
                else
                begin
                    col_reg <= AW'(c_next);
                    row_reg <= r;
                end
            end
            meta_reg <= meta_next;
            if (s1_valid_reg)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= two_above_val;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= above_q;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= s1_elev_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_emit_reg <= emit;
            s1_meta_reg.valid <= 1'b0;
            s1_meta_reg.border <= border;
            s1_meta_reg.row <= cr;
            s1_meta_reg.col <= d8sd_pkg::COL_W'(cc);
            s1_meta_reg.last <= row_wrap && col_wrap;
            s1_idx_reg <= c;
            s1_elev_reg <= elev;
            s1_fwd_reg <= s1_valid_reg && (s1_idx_reg == c);
            s1_fwd_data_reg <= above_q;
        end
    end

    assign cells = win_reg;
    assign meta = meta_reg;

endmodule
`default_nettype wire

// ===== hdl/d8sd_back.sv =====
// Back end: drops, weighted slopes and the steepest-neighbor selection tree.
`timescale 1ns / 1ps
`default_nettype none
module d8sd_back #(
    parameter int ELEV_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [8:0][ELEV_BITS-1:0] cells,
    input  wire d8sd_pkg::meta_t           meta,
    output logic                           res_valid,
    output d8sd_pkg::result_t              res
);

    localparam int SW = ELEV_BITS + 15;
    localparam logic [7:0][3:0] NB_POS = {4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0, 4'd3};
    localparam logic [ELEV_BITS-1:0] SIGN_FLIP = {1'b1, {(ELEV_BITS-1){1'b0}}};

    logic [7:0][ELEV_BITS-1:0] drop_reg;
    logic [7:0]                down_reg;
    d8sd_pkg::meta_t           d_meta_reg;
    logic [7:0][SW-1:0]        slope_reg;
    d8sd_pkg::meta_t           s_meta_reg;
    logic                      r_valid_reg;
    d8sd_pkg::result_t         r_res_reg;

    logic [ELEV_BITS-1:0]      bc;
    logic [7:0][ELEV_BITS-1:0] bn;
    logic [7:0][SW-1:0]        slope;
    logic [3:0][SW-1:0]        l1_val;
    logic [3:0][2:0]           l1_idx;
    logic [1:0][SW-1:0]        l2_val;
    logic [1:0][2:0]           l2_idx;
    logic [SW-1:0]             best_val;
    logic [2:0]                best_idx;
    logic [d8sd_pkg::DIR_W-1:0] dir;

    always_comb
    begin
        bc = cells[4] ^ SIGN_FLIP;
        for (int n = 0; n < 8; n++)
        begin
            bn[n] = cells[NB_POS[n]] ^ SIGN_FLIP;
        end
    end

    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            if (!down_reg[n])
            begin
                slope[n] = '0;
            end
            else if (n % 2 == 1)
            begin
                slope[n] = SW'(drop_reg[n]) * SW'(d8sd_pkg::INV_SQRT2_Q15);
            end
            else
            begin
                slope[n] = SW'(drop_reg[n]) << 15;
            end
        end
    end

    // Ties keep the lower direction code.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (slope_reg[2*i+1] > slope_reg[2*i])
            begin
                l1_val[i] = slope_reg[2*i+1];
                l1_idx[i] = 3'(2*i+1);
            end
            else
            begin
                l1_val[i] = slope_reg[2*i];
                l1_idx[i] = 3'(2*i);
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (l1_val[2*i+1] > l1_val[2*i])
            begin
                l2_val[i] = l1_val[2*i+1];
                l2_idx[i] = l1_idx[2*i+1];
            end
            else
            begin
                l2_val[i] = l1_val[2*i];
                l2_idx[i] = l1_idx[2*i];
            end
        end
        if (l2_val[1] > l2_val[0])
        begin
            best_val = l2_val[1];
            best_idx = l2_idx[1];
        end
        else
        begin
            best_val = l2_val[0];
            best_idx = l2_idx[0];
        end
        if (s_meta_reg.border || (best_val == '0))
        begin
            dir = d8sd_pkg::NO_FLOW;
        end
        else
        begin
            dir = {1'b0, best_idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_meta_reg <= '0;
            s_meta_reg <= '0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            d_meta_reg <= meta;
            s_meta_reg <= d_meta_reg;
            r_valid_reg <= s_meta_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 8; n++)
        begin
            down_reg[n] <= bc > bn[n];
            drop_reg[n] <= bc - bn[n];
        end
        slope_reg <= slope;
        r_res_reg.direction <= dir;
        r_res_reg.centre_row <= s_meta_reg.row;
        r_res_reg.centre_col <= s_meta_reg.col;
        r_res_reg.frame_last <= s_meta_reg.last;
    end

    assign res_valid = r_valid_reg;
    assign res = r_res_reg;

endmodule
`default_nettype wire

// ===== hdl/d8sd_fifo.sv =====
// Result queue that holds finished words until they are popped.
`timescale 1ns / 1ps
`default_nettype none
module d8sd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire d8sd_pkg::result_t wr_data,
    input  wire logic              rd_en,
    output logic                   empty,
    output d8sd_pkg::result_t      rd_data
);

    localparam int PW = $clog2(d8sd_pkg::QUEUE_DEPTH);

    d8sd_pkg::result_t mem_reg [d8sd_pkg::QUEUE_DEPTH];
    logic [PW:0]       wr_ptr_reg;
    logic [PW:0]       rd_ptr_reg;

    assign empty = wr_ptr_reg == rd_ptr_reg;
    assign rd_data = mem_reg[rd_ptr_reg[PW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + (PW+1)'(1);
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg[PW-1:0]] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/d8_steepest_descent_direction_top.sv =====
// Top level of the D8 steepest-descent direction block.
//
//  Channel   Handshake        Payload
//  -------   ---------------  -----------------------------------------
//  pixel     push / full      elevation, frame_start
//  result    pop / empty      direction, centre_row, centre_col, frame_last
//  config    cfg_valid/ready  cfg_index, cfg_data (grid_width, grid_height)
//
// One pixel word is taken per cycle while full is low, and one result word can leave per cycle.
// A result passes through the stage-1, window, drop, slope and result registers into the queue.
// The line buffers are two RAMs with one write and one read port each; no
// clearing pass follows reset. The input reports full while eight result words
// are either in the pipeline or in the queue.
`timescale 1ns / 1ps
`default_nettype none
module d8_steepest_descent_direction_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int ELEV_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire d8sd_pkg::pixel_t                   pixel,
    input  wire logic                               pop,
    output logic                                    empty,
    output d8sd_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [d8sd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CNTW = $clog2(d8sd_pkg::QUEUE_DEPTH + 1);

    logic [d8sd_pkg::GW_W-1:0]  grid_width_reg;
    logic [d8sd_pkg::ROW_W-1:0] grid_height_reg;
    logic [CNTW-1:0]            credit_reg;
    logic [CNTW-1:0]            credit_next;

    logic                      take;
    logic                      emit_now;
    logic [8:0][ELEV_BITS-1:0] cells;
    d8sd_pkg::meta_t           meta;
    logic                      res_valid;
    d8sd_pkg::result_t         res;
    logic                      take_credit;
    logic                      give_credit;

    assign cfg_ready = 1'b1;
    assign full = credit_reg >= CNTW'(d8sd_pkg::QUEUE_DEPTH);
    assign take = push && !full;
    assign take_credit = take && emit_now;
    assign give_credit = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg;
        if (take_credit && !give_credit)
        begin
            credit_next = credit_reg + CNTW'(1);
        end
        else if (!take_credit && give_credit)
        begin
            credit_next = credit_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= 11'd1024;
            grid_height_reg <= 16'd1024;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    d8sd_pkg::CFG_GRID_WIDTH:
                    begin
                        grid_width_reg <= cfg_data[d8sd_pkg::GW_W-1:0];
                    end
                    d8sd_pkg::CFG_GRID_HEIGHT:
                    begin
                        grid_height_reg <= cfg_data;
                    end
                    default:
                    begin
                        grid_width_reg <= grid_width_reg;
                    end
                endcase
            end
        end
    end

    d8sd_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .ELEV_BITS(ELEV_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .grid_width(grid_width_reg),
        .grid_height(grid_height_reg),
        .take(take),
        .pixel(pixel),
        .emit_now(emit_now),
        .cells(cells),
        .meta(meta)
    );

    d8sd_back #(
        .ELEV_BITS(ELEV_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cells(cells),
        .meta(meta),
        .res_valid(res_valid),
        .res(res)
    );

    d8sd_fifo u_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(res_valid),
        .wr_data(res),
        .rd_en(pop),
        .empty(empty),
        .rd_data(result)
    );

endmodule
`default_nettype wire
